// ===== sv/pebm_pkg.sv =====
// pebm_pkg: shared widths, register indexes, reset values and control structs
package pebm_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROTATIONS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_INTERVAL = 3'd5;

  // register reset values
  localparam logic [7:0]  RST_DEBOUNCE       = 8'd10;
  localparam logic [15:0] RST_WINDOW         = 16'd1000;
  localparam logic [7:0]  RST_MAX_ROTATIONS  = 8'd50;
  localparam logic [15:0] RST_IDLE_TIMEOUT   = 16'd3000;
  localparam logic [6:0]  RST_DECAY_STEP     = 7'd4;
  localparam logic [15:0] RST_DECAY_INTERVAL = 16'd1000;

  // payload widths
  localparam int unsigned ENERGY_W = 7;
  localparam int unsigned LIT_W    = 5;
  localparam int unsigned MASK_W   = 25;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = 7'd100;

  // gain divider: dividend covers 255*100
  localparam int unsigned DIV_N_W = 15;
  localparam int unsigned DIV_D_W = 8;

  typedef struct packed {
    logic accept;
    logic start_gain;
    logic apply;
    logic start_lit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/pebm_intf.sv =====
// pebm_intf: valid/ready channel interfaces for tick, result and configuration

interface pebm_in_if;
  logic valid;
  logic ready;
  logic sensor_level;

  modport source (output valid, output sensor_level, input ready);
  modport sink   (input valid, input sensor_level, output ready);
endinterface

interface pebm_out_if;
  logic                                valid;
  logic                                ready;
  logic [pebm_pkg::ENERGY_W-1:0]       energy_percent;
  logic [pebm_pkg::LIT_W-1:0]          lit_count;
  logic [pebm_pkg::MASK_W-1:0]         led_mask;
  logic                                display_update;
  logic                                rotation_pulse;

  modport source (output valid, output energy_percent, output lit_count, output led_mask,
                  output display_update, output rotation_pulse, input ready);
  modport sink   (input valid, input energy_percent, input lit_count, input led_mask,
                  input display_update, input rotation_pulse, output ready);
endinterface

interface pebm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pebm_pkg::CFG_IDX_W-1:0]    index;
  logic [pebm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/pebm_div.sv =====
// pebm_div: restoring divider, one quotient bit per cycle
module pebm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pebm_pkg::DIV_N_W-1:0]   dividend_i,
  input  logic [pebm_pkg::DIV_D_W-1:0]   divisor_i,
  output logic                           busy_o,
  output logic [pebm_pkg::DIV_N_W-1:0]   quotient_o
);

  localparam int unsigned CntW = $clog2(pebm_pkg::DIV_N_W + 1);

  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic                            busy_q, busy_d;
  logic [pebm_pkg::DIV_D_W-1:0]    rem_q, rem_d;
  logic [pebm_pkg::DIV_D_W-1:0]    dvs_q, dvs_d;
  logic [pebm_pkg::DIV_N_W-1:0]    quo_q, quo_d;
  logic [pebm_pkg::DIV_D_W:0]      trial;
  logic [pebm_pkg::DIV_D_W:0]      diff;
  logic                            ge;

  assign trial = {rem_q, quo_q[pebm_pkg::DIV_N_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d  = CntW'(pebm_pkg::DIV_N_W);
      busy_d = 1'b1;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low bits are enough
      rem_d  = ge ? diff[pebm_pkg::DIV_D_W-1:0] : trial[pebm_pkg::DIV_D_W-1:0];
      quo_d  = {quo_q[pebm_pkg::DIV_N_W-2:0], ge};
      cnt_d  = cnt_q - CntW'(1);
      busy_d = (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/pebm_ctrl.sv =====
// pebm_ctrl: sequencer for one tick, from acceptance to result load
module pebm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pebm_pkg::sts_t  sts_i,
  output pebm_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_GAIN  = 3'd2;
  localparam logic [2:0] ST_APPLY = 3'd3;
  localparam logic [2:0] ST_LITGO = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.need_div) begin
          cmd_o.start_gain = 1'b1;
          state_d          = ST_GAIN;
        end else begin
          state_d = ST_APPLY;
        end
      end
      ST_GAIN: begin
        if (!sts_i.div_busy) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_LITGO;
      end
      ST_LITGO: begin
        cmd_o.start_lit = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_gain |=> sts_i.div_busy)
    else $error("divider not busy after start");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (!in_ready_o && !cmd_o.load_out))
    else $error("tick accepted without sequencing");

endmodule

// ===== sv/pebm_dp.sv =====
// pebm_dp: registers, counters, energy update, divider and result register
module pebm_dp #(
  parameter int unsigned LED_COUNT = 25
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 sensor_level_i,
  input  pebm_pkg::cmd_t       cmd_i,
  output pebm_pkg::sts_t       sts_o,
  pebm_cfg_if.sink             cfg_i,
  pebm_out_if.source           out_o
);

  localparam logic [pebm_pkg::ENERGY_W-1:0] Full = pebm_pkg::ENERGY_MAX;

  // x/100 == (x*5243)>>19 for every x below 43690, bar product tops out at 2500
  localparam int unsigned BarW     = 12;
  localparam int unsigned ProdW    = 25;
  localparam int unsigned LitW     = 6;
  localparam int unsigned LitRecip = 5243;
  localparam int unsigned LitShift = 19;

  // configuration registers
  logic [7:0]  debounce_q, max_rot_q;
  logic [15:0] window_q, idle_to_q, interval_q;
  logic [6:0]  step_q;

  // tick state
  logic        last_level_q, last_level_d;
  logic        armed_q, armed_d;
  logic [7:0]  since_q, since_d;
  logic [15:0] win_q, win_d;
  logic [7:0]  rot_q, rot_d;
  logic [6:0]  energy_q, energy_d;
  logic [15:0] idle_q, idle_d;
  logic [15:0] wait_q, wait_d;
  logic        pulse_q, pulse_d;
  logic        update_q, update_d;

  // result register
  logic                            out_valid_q, out_valid_d;
  logic [pebm_pkg::ENERGY_W-1:0]   out_energy_q;
  logic [pebm_pkg::LIT_W-1:0]      out_lit_q;
  logic [pebm_pkg::MASK_W-1:0]     out_mask_q;
  logic                            out_update_q, out_pulse_q;
  logic [pebm_pkg::MASK_W-1:0]     mask;

  // divider
  logic                            div_start, div_busy;
  logic [pebm_pkg::DIV_N_W-1:0]    div_n, div_q;
  logic [pebm_pkg::DIV_D_W-1:0]    div_d;

  // bar length
  logic [BarW-1:0]                 bar_n;
  logic [ProdW-1:0]                bar_prod;
  logic [LitW-1:0]                 lit_q, lit_d;

  // per-tick combinational terms
  logic [7:0]  since_inc, rot_inc;
  logic [15:0] win_inc, idle_inc, wait_inc;
  logic        change, rotation, win_hit;
  logic [6:0]  gain, e_win, e_dec;
  logic [7:0]  sum;
  logic        decay_hit;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= pebm_pkg::RST_DEBOUNCE;
      window_q   <= pebm_pkg::RST_WINDOW;
      max_rot_q  <= pebm_pkg::RST_MAX_ROTATIONS;
      idle_to_q  <= pebm_pkg::RST_IDLE_TIMEOUT;
      step_q     <= pebm_pkg::RST_DECAY_STEP;
      interval_q <= pebm_pkg::RST_DECAY_INTERVAL;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        pebm_pkg::CFG_DEBOUNCE:       debounce_q <= cfg_i.data[7:0];
        pebm_pkg::CFG_WINDOW:         window_q   <= cfg_i.data;
        pebm_pkg::CFG_MAX_ROTATIONS:  max_rot_q  <= cfg_i.data[7:0];
        pebm_pkg::CFG_IDLE_TIMEOUT:   idle_to_q  <= cfg_i.data;
        pebm_pkg::CFG_DECAY_STEP:     step_q     <= cfg_i.data[6:0];
        pebm_pkg::CFG_DECAY_INTERVAL: interval_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // saturating time counters
  assign since_inc = (since_q == 8'hFF)    ? since_q : since_q + 8'd1;
  assign win_inc   = (win_q   == 16'hFFFF) ? win_q   : win_q + 16'd1;
  assign idle_inc  = (idle_q  == 16'hFFFF) ? idle_q  : idle_q + 16'd1;
  assign wait_inc  = (wait_q  == 16'hFFFF) ? wait_q  : wait_q + 16'd1;
  assign rot_inc   = (rot_q   == 8'hFF)    ? rot_q   : rot_q + 8'd1;

  assign change   = (sensor_level_i != last_level_q) && (since_inc > debounce_q);
  assign rotation = change && sensor_level_i && armed_q;

  // window close and gain
  assign win_hit = (win_q >= window_q);
  always_comb begin
    if (!win_hit || rot_q == 8'd0)                         gain = '0;
    else if (max_rot_q == 8'd0)                            gain = Full;
    else if (div_q > pebm_pkg::DIV_N_W'(Full))             gain = Full;
    else                                                   gain = div_q[6:0];
  end
  assign sum   = {1'b0, energy_q} + {1'b0, gain};
  assign e_win = (sum > {1'b0, Full}) ? Full : sum[6:0];

  // decay after the window update
  assign decay_hit = (idle_q >= idle_to_q) && (e_win != '0) && (wait_q >= interval_q);
  assign e_dec     = (e_win > step_q) ? e_win - step_q : '0;

  always_comb begin
    last_level_d = last_level_q;
    armed_d      = armed_q;
    since_d      = since_q;
    win_d        = win_q;
    rot_d        = rot_q;
    energy_d     = energy_q;
    idle_d       = idle_q;
    wait_d       = wait_q;
    pulse_d      = pulse_q;
    update_d     = update_q;
    if (cmd_i.accept) begin
      last_level_d = sensor_level_i;
      since_d      = change ? 8'd0 : since_inc;
      win_d        = win_inc;
      wait_d       = wait_inc;
      idle_d       = rotation ? 16'd0 : idle_inc;
      rot_d        = rotation ? rot_inc : rot_q;
      pulse_d      = rotation;
      if (change) begin
        if (!sensor_level_i) armed_d = 1'b1;
        else if (armed_q)    armed_d = 1'b0;
      end
    end
    if (cmd_i.apply) begin
      if (win_hit) begin
        rot_d = '0;
        win_d = '0;
      end
      if ((idle_q >= idle_to_q) && (e_win != '0)) begin
        if (decay_hit) wait_d = '0;
      end else begin
        wait_d = '0;
      end
      energy_d = decay_hit ? e_dec : e_win;
      update_d = win_hit || decay_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b1;
      armed_q      <= 1'b0;
      since_q      <= 8'hFF;
      win_q        <= '0;
      rot_q        <= '0;
      energy_q     <= '0;
      idle_q       <= '0;
      wait_q       <= '0;
      pulse_q      <= 1'b0;
      update_q     <= 1'b0;
    end else begin
      last_level_q <= last_level_d;
      armed_q      <= armed_d;
      since_q      <= since_d;
      win_q        <= win_d;
      rot_q        <= rot_d;
      energy_q     <= energy_d;
      idle_q       <= idle_d;
      wait_q       <= wait_d;
      pulse_q      <= pulse_d;
      update_q     <= update_d;
    end
  end

  // divider for the window gain
  assign div_start = cmd_i.start_gain;
  assign div_n     = pebm_pkg::DIV_N_W'(rot_q) * pebm_pkg::DIV_N_W'(Full);
  assign div_d     = max_rot_q;

  pebm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .busy_o     (div_busy),
    .quotient_o (div_q)
  );

  // bar length from the settled energy, registered
  assign bar_n    = BarW'(energy_q) * BarW'(LED_COUNT);
  assign bar_prod = ProdW'(bar_n) * ProdW'(LitRecip);
  assign lit_d    = cmd_i.start_lit ? bar_prod[ProdW-1:LitShift] : lit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q <= '0;
    end else begin
      lit_q <= lit_d;
    end
  end

  always_comb begin
    for (int i = 0; i < pebm_pkg::MASK_W; i++) begin
      mask[i] = (lit_q > LitW'(i));
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out)   out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_energy_q <= energy_q;
      out_lit_q    <= lit_q[pebm_pkg::LIT_W-1:0];
      out_mask_q   <= mask;
      out_update_q <= update_q;
      out_pulse_q  <= pulse_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.energy_percent = out_energy_q;
  assign out_o.lit_count      = out_lit_q;
  assign out_o.led_mask       = out_mask_q;
  assign out_o.display_update = out_update_q;
  assign out_o.rotation_pulse = out_pulse_q;

  assign sts_o.need_div = win_hit && (rot_q != 8'd0) && (max_rot_q != 8'd0);
  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = !out_valid_q || out_o.ready;

  a_energy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    energy_q <= Full)
    else $error("energy above full scale");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_o.ready))
    else $error("result register overwritten");

  a_start_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_lit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (lit_q <= LitW'(LED_COUNT)))
    else $error("bar length above led count");

endmodule

// ===== sv/pedal_energy_bar_meter.sv =====
// pedal_energy_bar_meter: top level of the pedal energy bar meter
//
// usage
// - in_i carries one transaction per 1 ms tick with the sampled hall level
//   (0 magnet near, 1 magnet away); in_i.ready is high only between ticks
// - out_o returns exactly one transaction per tick: energy in percent, the
//   number of lit bar leds, the bar mask and the update/rotation flags
// - cfg_i writes one setting per transaction (index 0 debounce, 1 window,
//   2 max rotations, 3 idle timeout, 4 decay step, 5 decay interval); it is
//   always ready and is meant to be written only while no tick is in flight
// - timing: an accepted tick runs through check, the 15-step restoring
//   divider for the window gain when a window closes with rotations and a
//   nonzero max rotations, apply and the registered reciprocal multiply for
//   the bar length before its result sits in the output register
// - flow: no new tick is taken before the result of the last is loaded; the
//   output register frees the input side once a result is loaded
// - stall: a result waits in the output register while out_o.ready is low;
//   the next tick is still taken and holds before loading until it frees
// - reset: all settings return to their defaults, energy and counters clear,
//   the debounce timer starts saturated and the last level starts high
module pedal_energy_bar_meter #(
  parameter int unsigned LED_COUNT = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pebm_in_if.sink     in_i,
  pebm_cfg_if.sink    cfg_i,
  pebm_out_if.source  out_o
);

  // command and status between sequencer and datapath
  pebm_pkg::cmd_t cmd;
  pebm_pkg::sts_t sts;
  logic           in_ready;

  // tick channel handshake is owned by the sequencer
  assign in_i.ready = in_ready;

  pebm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: settings, timers, energy, divider, result register
  pebm_dp #(
    .LED_COUNT (LED_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sensor_level_i (in_i.sensor_level),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_i          (cfg_i),
    .out_o          (out_o)
  );

endmodule
